// ===== rtl/core/bdpc_pkg.sv =====
// shared types and codes for the button debounce press classifier
package bdpc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned DEB_W  = 16;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned EV_W   = 2;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned DATA_W = 32;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_EDGE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPEAT   = 2'd2;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_PRESS = 2'd1;
    localparam logic [EV_W-1:0] EV_SHORT = 2'd2;
    localparam logic [EV_W-1:0] EV_LONG  = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MODE            = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE        = 3'd1;
    localparam logic [IDX_W-1:0] REG_LONG_PRESS      = 3'd2;
    localparam logic [IDX_W-1:0] REG_REPEAT_DELAY    = 3'd3;
    localparam logic [IDX_W-1:0] REG_REPEAT_INTERVAL = 3'd4;

    // reset values
    localparam logic [MODE_W-1:0] RST_MODE            = MODE_CLASSIFY;
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE        = 16'd35;
    localparam logic [TIME_W-1:0] RST_LONG_PRESS      = 32'd1000;
    localparam logic [TIME_W-1:0] RST_REPEAT_DELAY    = 32'd500;
    localparam logic [TIME_W-1:0] RST_REPEAT_INTERVAL = 32'd150;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DEB_W-1:0]  settle_ms;
        logic [TIME_W-1:0] long_press_ms;
        logic [TIME_W-1:0] repeat_delay_ms;
        logic [TIME_W-1:0] repeat_interval_ms;
    } t_cfg;

endpackage

// ===== rtl/core/bdpc_regs.sv =====
// configuration register file
module bdpc_regs
    import bdpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:            n_cfg.mode               = i_cfg_data[MODE_W-1:0];
                REG_DEBOUNCE:        n_cfg.settle_ms          = i_cfg_data[DEB_W-1:0];
                REG_LONG_PRESS:      n_cfg.long_press_ms      = i_cfg_data[TIME_W-1:0];
                REG_REPEAT_DELAY:    n_cfg.repeat_delay_ms    = i_cfg_data[TIME_W-1:0];
                REG_REPEAT_INTERVAL: n_cfg.repeat_interval_ms = i_cfg_data[TIME_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode               <= RST_MODE;
            r_cfg.settle_ms          <= RST_DEBOUNCE;
            r_cfg.long_press_ms      <= RST_LONG_PRESS;
            r_cfg.repeat_delay_ms    <= RST_REPEAT_DELAY;
            r_cfg.repeat_interval_ms <= RST_REPEAT_INTERVAL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/bdpc_core.sv =====
// debounce state and press classification, one sample per update
module bdpc_core
    import bdpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_now_ms,
    input  t_cfg              i_cfg,
    output logic [EV_W-1:0]   o_button_event
);

    logic              r_raw, n_raw;
    logic              r_stable, n_stable;
    logic [TIME_W-1:0] r_chg_time, n_chg_time;
    logic [TIME_W-1:0] r_press_time, n_press_time;
    logic [TIME_W-1:0] r_rep_time, n_rep_time;
    logic              r_long, n_long;

    logic              raw_change;
    logic [TIME_W-1:0] d_chg, d_press, d_rep;
    logic              settled;
    logic              changed;
    logic [EV_W-1:0]   ev;

    // wrapping time differences, all in parallel
    assign raw_change = (i_level != r_raw);
    assign d_chg      = raw_change ? '0 : (i_now_ms - r_chg_time);
    assign d_press    = i_now_ms - r_press_time;
    assign d_rep      = i_now_ms - r_rep_time;
    assign settled    = (d_chg >= {{(TIME_W-DEB_W){1'b0}}, i_cfg.settle_ms});
    assign changed    = settled && (i_level != r_stable);

    always_comb begin
        n_raw        = r_raw;
        n_stable     = r_stable;
        n_chg_time   = r_chg_time;
        n_press_time = r_press_time;
        n_rep_time   = r_rep_time;
        n_long       = r_long;
        ev           = EV_NONE;
        if (raw_change) begin
            n_raw      = i_level;
            n_chg_time = i_now_ms;
        end
        case (i_cfg.mode)
            MODE_CLASSIFY: begin
                if (changed) begin
                    n_stable = i_level;
                    if (!i_level) begin
                        n_press_time = i_now_ms;
                        n_long       = 1'b0;
                    end else begin
                        ev = r_long ? EV_NONE : EV_SHORT;
                    end
                end else if (settled && !r_stable && !r_long &&
                             (d_press >= i_cfg.long_press_ms)) begin
                    n_long = 1'b1;
                    ev     = EV_LONG;
                end
            end
            MODE_REPEAT: begin
                if (changed) begin
                    n_stable = i_level;
                    if (!i_level) begin
                        n_press_time = i_now_ms;
                        n_rep_time   = i_now_ms;
                        ev           = EV_PRESS;
                    end
                end else if (!r_stable && (d_press >= i_cfg.repeat_delay_ms) &&
                             (d_rep >= i_cfg.repeat_interval_ms)) begin
                    n_rep_time = i_now_ms;
                    ev         = EV_PRESS;
                end
            end
            default: begin
                // plain edge mode, unused code behaves the same
                if (changed) begin
                    n_stable = i_level;
                    if (!i_level) begin
                        n_press_time = i_now_ms;
                        n_rep_time   = i_now_ms;
                        n_long       = 1'b0;
                        ev           = EV_PRESS;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw        <= 1'b1;
            r_stable     <= 1'b1;
            r_chg_time   <= '0;
            r_press_time <= '0;
            r_rep_time   <= '0;
            r_long       <= 1'b0;
        end else if (i_step) begin
            r_raw        <= n_raw;
            r_stable     <= n_stable;
            r_chg_time   <= n_chg_time;
            r_press_time <= n_press_time;
            r_rep_time   <= n_rep_time;
            r_long       <= n_long;
        end
    end

    assign o_button_event = ev;

endmodule

// ===== rtl/core/button_debounce_press_classifier.sv =====
// top level: sample register, classifier state and result register
// path: an input transfer loads the sample register, a step then loads the result register (two register stages)
// throughput: one sample per cycle unless the result side stalls, set by the state update loop in bdpc_core
// back-pressure: sample register and result register each hold one item
// reset (i_rst_n low, synchronous): released button at time 0, registers at defaults,
// both stages empty
module button_debounce_press_classifier
    import bdpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_now_ms,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [EV_W-1:0]   o_button_event,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;

    // sample register
    logic              r_in_valid;
    logic              r_level;
    logic [TIME_W-1:0] r_now_ms;

    // result register
    logic              r_out_valid;
    logic [EV_W-1:0]   r_event;

    logic              in_xfer;
    logic              step;
    logic [EV_W-1:0]   step_event;

    // a held sample is classified whenever the result register can take it
    assign step    = r_in_valid && (!r_out_valid || i_ready);
    // sample register refills in the same cycle it drains
    assign o_ready = !r_in_valid || step;
    assign in_xfer = i_valid && o_ready;

    bdpc_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bdpc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_level        (r_level),
        .i_now_ms       (r_now_ms),
        .i_cfg          (cfg),
        .o_button_event (step_event)
    );

    // sample stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // sample payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_level  <= i_level;
            r_now_ms <= i_now_ms;
        end
    end

    // result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event <= step_event;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_button_event = r_event;

endmodule

// ===== rtl/core/bdpc_checker.sv =====
// port-level checks for the button debounce press classifier
module bdpc_checker
    import bdpc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [EV_W-1:0]   o_button_event
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_button_event))
        else $error("result changed while stalled");

    // input side only stalls when the result side is full and stalled
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without output back-pressure");

    // both stages empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid && o_ready)
        else $error("stages not empty after reset");

    // a result can only appear after a sample transfer: with the sample stage
    // left empty and no result held, nothing shows up next cycle
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_ready && !i_valid) && !o_valid |=> !o_valid)
        else $error("result without sample");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (.*);

// ===== bench/testbench.sv =====
// self-checking testbench for the button debounce press classifier
module testbench
    import bdpc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // pin levels, active low button
    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    // mode value that the block treats as press edge
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned RESULT_LATENCY = 2;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_SAMPLES  = 210;

    // expected event tracker: debounce and press classification state
    class press_scoreboard;
        logic [MODE_W-1:0] mode;
        logic [DEB_W-1:0]  settle_ms;
        logic [TIME_W-1:0] long_press_ms;
        logic [TIME_W-1:0] repeat_delay_ms;
        logic [TIME_W-1:0] repeat_interval_ms;
        logic              raw_level;
        logic              stable_level;
        logic              long_reported;
        logic [TIME_W-1:0] change_time;
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] repeat_time;
        logic [EV_W-1:0]   expected_events[$];
        int unsigned       errors;

        function new();
            mode               = RST_MODE;
            settle_ms          = RST_DEBOUNCE;
            long_press_ms      = RST_LONG_PRESS;
            repeat_delay_ms    = RST_REPEAT_DELAY;
            repeat_interval_ms = RST_REPEAT_INTERVAL;
            raw_level          = LVL_RELEASED;
            stable_level       = LVL_RELEASED;
            long_reported      = 1'b0;
            change_time        = '0;
            press_time         = '0;
            repeat_time        = '0;
            errors             = 0;
        endfunction

        function void note_config(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_MODE:            mode               = data[MODE_W-1:0];
                REG_DEBOUNCE:        settle_ms          = data[DEB_W-1:0];
                REG_LONG_PRESS:      long_press_ms      = data[TIME_W-1:0];
                REG_REPEAT_DELAY:    repeat_delay_ms    = data[TIME_W-1:0];
                REG_REPEAT_INTERVAL: repeat_interval_ms = data[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic lvl, logic [TIME_W-1:0] now);
            logic [EV_W-1:0]   ev;
            logic [TIME_W-1:0] since_change;
            logic [TIME_W-1:0] since_press;
            logic [TIME_W-1:0] since_repeat;
            logic              settled;
            ev = EV_NONE;
            if (lvl != raw_level) begin
                raw_level   = lvl;
                change_time = now;
            end
            since_change = now - change_time;
            settled      = since_change >= TIME_W'(settle_ms);
            case (mode)
                MODE_CLASSIFY: begin
                    if (settled && lvl != stable_level) begin
                        stable_level = lvl;
                        if (lvl == LVL_PRESSED) begin
                            press_time    = now;
                            long_reported = 1'b0;
                        end else if (!long_reported) begin
                            ev = EV_SHORT;
                        end
                    end else if (settled && stable_level == LVL_PRESSED && !long_reported) begin
                        since_press = now - press_time;
                        if (since_press >= long_press_ms) begin
                            long_reported = 1'b1;
                            ev            = EV_LONG;
                        end
                    end
                end
                MODE_REPEAT: begin
                    if (settled && lvl != stable_level) begin
                        stable_level = lvl;
                        if (lvl == LVL_PRESSED) begin
                            press_time  = now;
                            repeat_time = now;
                            ev          = EV_PRESS;
                        end
                    end
                    if (ev == EV_NONE && stable_level == LVL_PRESSED) begin
                        since_press  = now - press_time;
                        since_repeat = now - repeat_time;
                        if (since_press >= repeat_delay_ms &&
                            since_repeat >= repeat_interval_ms) begin
                            repeat_time = now;
                            ev          = EV_PRESS;
                        end
                    end
                end
                default: begin
                    // press edge mode, also taken by the spare mode value
                    if (settled && lvl != stable_level) begin
                        stable_level = lvl;
                        if (lvl == LVL_PRESSED) begin
                            press_time    = now;
                            repeat_time   = now;
                            long_reported = 1'b0;
                            ev            = EV_PRESS;
                        end
                    end
                end
            endcase
            expected_events.push_back(ev);
        endfunction

        function void check_event(logic [EV_W-1:0] got);
            logic [EV_W-1:0] want;
            if (expected_events.size() == 0) begin
                $error("button_event: no result expected, got %0d", got);
                errors++;
            end else begin
                want = expected_events.pop_front();
                if (got !== want) begin
                    $error("button_event: expected %0d, got %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic              o_ready;
    logic              i_level    = LVL_RELEASED;
    logic [TIME_W-1:0] i_now_ms   = '0;
    logic              o_valid;
    logic              i_ready    = 1'b0;
    logic [EV_W-1:0]   o_button_event;
    logic              i_cfg_we   = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx  = '0;
    logic [DATA_W-1:0] i_cfg_data = '0;

    press_scoreboard board = new();

    // running millisecond clock seen by the button, wraps naturally
    logic [TIME_W-1:0] clock_ms = '0;
    int unsigned       send_idle_pct = 0;
    int unsigned       stall_pct     = 0;
    int unsigned       phase_samples = 0;
    int unsigned       quiet_cycles  = 0;

    button_debounce_press_classifier i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_level        (i_level),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_button_event (o_button_event),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // receiver back-pressure, random per cycle at the current stall rate
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // every result transfer is checked against the oldest expected event
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_event(o_button_event);
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one sample transfer; valid stays high into the next call unless it idles
    task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_level  <= lvl;
        i_now_ms <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_sample(lvl, now);
        phase_samples++;
    endtask

    // stop sending and let every expected event come out
    task automatic wait_results_done();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // caller lowers the write enable after the last write of a batch
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.note_config(idx, data);
    endtask

    task automatic apply_setting(input logic [MODE_W-1:0] mode, input logic [DEB_W-1:0] deb,
                                 input logic [TIME_W-1:0] long_ms,
                                 input logic [TIME_W-1:0] delay_ms,
                                 input logic [TIME_W-1:0] interval_ms);
        logic [DATA_W-1:0] data;
        wait_results_done();
        repeat (RESULT_LATENCY + 1) @(posedge i_clk);
        // unused indexes get junk that must be dropped
        for (int k = REG_REPEAT_INTERVAL + 1; k < 2 ** IDX_W; k++) begin
            write_reg(IDX_W'(k), $urandom());
        end
        // upper bits beyond the register width are junk too
        data = $urandom();
        data[MODE_W-1:0] = mode;
        write_reg(REG_MODE, data);
        data = $urandom();
        data[DEB_W-1:0] = deb;
        write_reg(REG_DEBOUNCE, data);
        write_reg(REG_LONG_PRESS, long_ms);
        write_reg(REG_REPEAT_DELAY, delay_ms);
        write_reg(REG_REPEAT_INTERVAL, interval_ms);
        i_cfg_we <= 1'b0;
    endtask

    // bounce, hold pressed, bounce, hold released
    task automatic press_cycle(input int unsigned bounce_step, input int unsigned hold_step,
                               input bit full_hold);
        int unsigned bounces;
        int unsigned held;
        bounces = $urandom_range(0, 5);
        for (int k = 0; k < bounces; k++) begin
            send_sample((k % 2 == 0) ? LVL_PRESSED : LVL_RELEASED, clock_ms);
            clock_ms += $urandom_range(0, bounce_step);
        end
        // a broken sequence lets go before the debounce window can close
        held = full_hold ? $urandom_range(1, 30) : $urandom_range(0, 2);
        for (int k = 0; k < held; k++) begin
            send_sample(LVL_PRESSED, clock_ms);
            clock_ms += full_hold ? $urandom_range(1, hold_step) : $urandom_range(0, bounce_step);
        end
        bounces = $urandom_range(0, 5);
        for (int k = 0; k < bounces; k++) begin
            send_sample((k % 2 == 0) ? LVL_RELEASED : LVL_PRESSED, clock_ms);
            clock_ms += $urandom_range(0, bounce_step);
        end
        held = $urandom_range(1, 8);
        for (int k = 0; k < held; k++) begin
            send_sample(LVL_RELEASED, clock_ms);
            clock_ms += $urandom_range(1, hold_step);
        end
    endtask

    task automatic run_phase(input int unsigned phase, input logic [MODE_W-1:0] mode,
                             input logic [DEB_W-1:0] deb, input logic [TIME_W-1:0] long_ms,
                             input logic [TIME_W-1:0] delay_ms,
                             input logic [TIME_W-1:0] interval_ms,
                             input int unsigned bounce_step, input int unsigned hold_step);
        int unsigned pick;
        apply_setting(mode, deb, long_ms, delay_ms, interval_ms);
        // rotate through no idling, sender gaps, receiver stalls, both
        case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 62; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 62; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
        endcase
        phase_samples = 0;
        while (phase_samples < PHASE_SAMPLES) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                press_cycle(bounce_step, hold_step, 1'b1);
            end else if (pick == 7) begin
                press_cycle(bounce_step, hold_step, 1'b0);
            end else begin
                // noise: random level with a nearby or fully random timestamp
                send_sample(logic'($urandom_range(0, 1)),
                            $urandom_range(0, 1) ? TIME_W'($urandom())
                                                 : clock_ms + $urandom_range(0, hold_step));
            end
            // now and then the sender holds off until the block has drained
            if ($urandom_range(0, 49) == 0) begin
                wait_results_done();
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings: classify mode, 35 ms debounce, 1 s long press
        send_sample(LVL_RELEASED, 32'd0);
        send_sample(LVL_PRESSED,  32'd10);
        send_sample(LVL_RELEASED, 32'd15);
        send_sample(LVL_PRESSED,  32'd20);
        send_sample(LVL_PRESSED,  32'd54);    // one short of the window
        send_sample(LVL_PRESSED,  32'd55);    // press settles, silent
        send_sample(LVL_PRESSED,  32'd1054);
        send_sample(LVL_PRESSED,  32'd1055);  // long press
        send_sample(LVL_PRESSED,  32'd1100);
        send_sample(LVL_RELEASED, 32'd1200);
        send_sample(LVL_RELEASED, 32'd1235);  // release after long press stays silent
        send_sample(LVL_PRESSED,  32'd1300);
        send_sample(LVL_PRESSED,  32'd1335);
        send_sample(LVL_RELEASED, 32'd1400);
        send_sample(LVL_RELEASED, 32'd1435);  // short press
        // debounce and long press across the timestamp wrap
        send_sample(LVL_PRESSED,  32'hFFFF_FFF0);
        send_sample(LVL_PRESSED,  32'h0000_0013);
        send_sample(LVL_PRESSED,  32'hFFFF_FFFF);
        send_sample(LVL_RELEASED, 32'h0000_0000);
        send_sample(LVL_RELEASED, 32'h0000_0030);

        run_phase(0, MODE_EDGE,     16'd35,    32'd1000, 32'd500, 32'd150, 8, 40);
        run_phase(1, MODE_REPEAT,   16'd20,    32'd1000, 32'd500, 32'd150, 5, 40);
        // zero thresholds: a long press fires on the first held sample, repeats fire on every held sample
        run_phase(2, MODE_CLASSIFY, 16'd0,     32'd0,    32'd500, 32'd150, 3, 10);
        run_phase(3, MODE_REPEAT,   16'd0,     32'd1000, 32'd0,   32'd0,   3, 10);
        // largest debounce window, spare mode value
        run_phase(4, MODE_SPARE,    16'hFFFF,  32'd1000, 32'd500, 32'd150, 16000, 30000);
        run_phase(5, MODE_CLASSIFY, 16'hFFFF,  32'hFFFF_FFFF, 32'd500, 32'd150, 16000, 40000);
        run_phase(6, MODE_REPEAT,   16'd5,     32'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 30);
        run_phase(7, MODE_W'($urandom_range(0, 3)), DEB_W'($urandom_range(0, 100)),
                  $urandom_range(0, 2000), $urandom_range(0, 1000), $urandom_range(0, 300),
                  10, 60);
        // back to reset values with the clock just short of the wrap
        clock_ms = 32'hFFFF_F000;
        run_phase(8, RST_MODE, RST_DEBOUNCE, RST_LONG_PRESS, RST_REPEAT_DELAY,
                  RST_REPEAT_INTERVAL, 8, 60);

        wait_results_done();
        repeat (RESULT_LATENCY + 6) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bdpc_pkg.sv
rtl/core/bdpc_regs.sv
rtl/core/bdpc_core.sv
rtl/core/button_debounce_press_classifier.sv
rtl/core/bdpc_checker.sv
bench/testbench.sv
